FILE: sv/mard_pkg.sv
package mard_pkg;

    localparam int SND_W   = 32;
    localparam int SER_W   = 32;
    localparam int TIME_W  = 48;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 3;
    localparam int WS_W    = 5;
    localparam int THR_W   = 16;
    localparam int SCORE_W = 16;
    localparam int DEV_W   = TIME_W + 1;
    localparam int NUM_W   = 62;
    localparam int DEN_W   = 25;

    localparam int RATE_LIMIT    = 12;
    localparam int RATE_BASE     = 10;
    localparam int ONE_SECOND_US = 1000000;

    localparam logic [CIDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_EXPECTED    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TOLERANCE   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_REPLAY_MODE = 3'd4;

    localparam logic [WS_W-1:0]  RST_WINDOW_SIZE = 5'd16;
    localparam logic [THR_W-1:0] RST_THRESHOLD   = 16'd256;
    localparam logic [CFG_W-1:0] RST_EXPECTED    = 20'd100000;
    localparam logic [CFG_W-1:0] RST_TOLERANCE   = 20'd50000;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SEEN   = 10'b0000000010,
        S_SLOT   = 10'b0000000100,
        S_HIST   = 10'b0000001000,
        S_CALC1  = 10'b0000010000,
        S_CALC2  = 10'b0000100000,
        S_CALC3  = 10'b0001000000,
        S_DSTART = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_WB     = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic start;
        logic seen_scan;
        logic slot_scan;
        logic hist_scan;
        logic calc1;
        logic calc2;
        logic calc3;
        logic div_start;
        logic wb;
    } t_cmd;

    typedef struct packed {
        logic seen_done;
        logic slot_done;
        logic hist_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/mard_div.sv
module mard_div import mard_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_done,
    output logic [SCORE_W-1:0] o_quot
);

    localparam int REM_W = DEN_W + SCORE_W;
    localparam int BIT_W = $clog2(SCORE_W);

    logic               r_busy;
    logic               r_done;
    logic [BIT_W-1:0]   r_bit;
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_trial;
    logic [SCORE_W-1:0] r_q;
    logic               sat;

    assign sat = i_num >= NUM_W'({i_den, {SCORE_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= !sat;
            r_done <= sat;
        end else if (r_busy && r_bit == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num[REM_W-1:0];
            r_trial <= REM_W'({i_den, {(SCORE_W-1){1'b0}}});
            r_bit   <= BIT_W'(SCORE_W - 1);
            r_q     <= sat ? {SCORE_W{1'b1}} : '0;
        end else if (r_busy) begin
            // one quotient bit per cycle, msb first
            if (r_rem >= r_trial) begin
                r_rem      <= r_rem - r_trial;
                r_q[r_bit] <= 1'b1;
            end
            r_trial <= r_trial >> 1;
            r_bit   <= r_bit - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider started while busy");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("divider busy and done together");

endmodule

FILE: sv/mard_dpath.sv
module mard_dpath import mard_pkg::*; #(
    parameter int SENDERS      = 64,
    parameter int WINDOW       = 16,
    parameter int SEEN_ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic [SND_W-1:0]   i_sender_address,
    input  logic [SER_W-1:0]   i_serial_number,
    input  logic [TIME_W-1:0]  i_receive_time,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_alert,
    output logic               o_replay_seen,
    output logic [SCORE_W-1:0] o_anomaly_score,
    output logic               o_sender_blocked
);

    localparam int SC_W = $clog2(SEEN_ENTRIES + 1);
    localparam int SI_W = $clog2(SEEN_ENTRIES);
    localparam int KC_W = $clog2(SENDERS + 1);
    localparam int KI_W = $clog2(SENDERS);
    localparam int FW   = $clog2(WINDOW + 1);
    localparam int HW   = $clog2(WINDOW);
    localparam int HA_W = $clog2(SENDERS * WINDOW);
    localparam int RM_W = FW + 4 + CFG_W;
    localparam int SW_W = SND_W + FW + HW + 1;

    // configuration
    logic [WS_W-1:0]  r_ws;
    logic [THR_W-1:0] r_thr;
    logic [CFG_W-1:0] r_exp;
    logic [CFG_W-1:0] r_tol;
    logic             r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws   <= RST_WINDOW_SIZE;
            r_thr  <= RST_THRESHOLD;
            r_exp  <= RST_EXPECTED;
            r_tol  <= RST_TOLERANCE;
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE: r_ws   <= i_cfg_data[WS_W-1:0];
                CFG_THRESHOLD:   r_thr  <= i_cfg_data[THR_W-1:0];
                CFG_EXPECTED:    r_exp  <= i_cfg_data;
                CFG_TOLERANCE:   r_tol  <= i_cfg_data;
                CFG_REPLAY_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // request latch
    logic [SND_W-1:0]  r_snd;
    logic [SER_W-1:0]  r_ser;
    logic [TIME_W-1:0] r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_snd <= i_sender_address;
            r_ser <= i_serial_number;
            r_now <= i_receive_time;
        end
    end

    // seen pair table, filled in order, then round-robin
    logic [SND_W+SER_W-1:0] seen_mem [SEEN_ENTRIES];
    logic [SND_W+SER_W-1:0] r_seen_rd;
    logic [SC_W-1:0]        r_seen_cnt;
    logic [SI_W-1:0]        r_seen_vic;
    logic [SC_W-1:0]        r_sa;
    logic                   r_s_cv;
    logic                   r_replay;
    logic                   seen_hit;
    logic                   seen_done;
    logic                   seen_full;
    logic [SI_W-1:0]        seen_ins;

    assign seen_hit  = r_s_cv && (r_seen_rd == {r_snd, r_ser});
    assign seen_done = r_s_cv ? seen_hit : (r_sa == r_seen_cnt);
    assign seen_full = r_seen_cnt == SC_W'(SEEN_ENTRIES);
    assign seen_ins  = seen_full ? r_seen_vic : r_seen_cnt[SI_W-1:0];

    always_ff @(posedge i_clk) begin
        r_seen_rd <= seen_mem[r_sa[SI_W-1:0]];
        if (i_cmd.seen_scan && seen_done && !seen_hit) begin
            seen_mem[seen_ins] <= {r_snd, r_ser};
        end
        if (i_cmd.seen_scan && seen_done) begin
            r_replay <= seen_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa       <= '0;
            r_s_cv     <= 1'b0;
            r_seen_cnt <= '0;
            r_seen_vic <= '0;
        end else if (i_cmd.start) begin
            r_sa   <= '0;
            r_s_cv <= 1'b0;
        end else if (i_cmd.seen_scan) begin
            if (seen_done) begin
                r_s_cv <= 1'b0;
                if (!seen_hit) begin
                    if (seen_full) begin
                        r_seen_vic <= (r_seen_vic == SI_W'(SEEN_ENTRIES - 1)) ?
                                      '0 : r_seen_vic + 1'b1;
                    end else begin
                        r_seen_cnt <= r_seen_cnt + 1'b1;
                    end
                end
            end else begin
                r_s_cv <= r_sa < r_seen_cnt;
                if (r_sa < r_seen_cnt) begin
                    r_sa <= r_sa + 1'b1;
                end
            end
        end
    end

    // sender slot table: {sender, fill, head, blacklisted}
    logic [SW_W-1:0]   slot_mem [SENDERS];
    logic [SW_W-1:0]   r_slot_rd;
    logic [KC_W-1:0]   r_slot_cnt;
    logic [KI_W-1:0]   r_slot_vic;
    logic [KC_W-1:0]   r_ka;
    logic [KI_W-1:0]   r_k_da;
    logic              r_k_cv;
    logic [KI_W-1:0]   r_slot;
    logic [FW-1:0]     r_fill;
    logic [HW-1:0]     r_head;
    logic              r_black;
    logic              slot_hit;
    logic              slot_done;
    logic              slot_full;
    logic [FW-1:0]     sel_fill;
    logic [HW-1:0]     sel_head;
    logic [FW:0]       p0_wide;
    logic [SW_W-1:0]   slot_wdata;

    assign slot_hit  = r_k_cv && (r_slot_rd[SW_W-1 -: SND_W] == r_snd);
    assign slot_done = r_k_cv ? slot_hit : (r_ka == r_slot_cnt);
    assign slot_full = r_slot_cnt == KC_W'(SENDERS);
    assign sel_fill  = slot_hit ? r_slot_rd[HW+1 +: FW] : '0;
    assign sel_head  = slot_hit ? r_slot_rd[1 +: HW] : '0;
    // oldest entry of the window
    assign p0_wide   = ((FW+1)'(sel_head) >= (FW+1)'(sel_fill)) ?
                       (FW+1)'(sel_head) - (FW+1)'(sel_fill) :
                       (FW+1)'(sel_head) + (FW+1)'(WINDOW) - (FW+1)'(sel_fill);

    always_ff @(posedge i_clk) begin
        r_slot_rd <= slot_mem[r_ka[KI_W-1:0]];
        if (i_cmd.wb) begin
            slot_mem[r_slot] <= slot_wdata;
        end
        if (i_cmd.slot_scan && !slot_done) begin
            r_k_da <= r_ka[KI_W-1:0];
        end
        if (i_cmd.slot_scan && slot_done) begin
            r_slot  <= slot_hit ? r_k_da : (slot_full ? r_slot_vic : r_slot_cnt[KI_W-1:0]);
            r_fill  <= sel_fill;
            r_head  <= sel_head;
            r_black <= slot_hit && r_slot_rd[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ka       <= '0;
            r_k_cv     <= 1'b0;
            r_slot_cnt <= '0;
            r_slot_vic <= '0;
        end else if (i_cmd.start) begin
            r_ka   <= '0;
            r_k_cv <= 1'b0;
        end else if (i_cmd.slot_scan) begin
            if (slot_done) begin
                r_k_cv <= 1'b0;
                if (!slot_hit) begin
                    if (slot_full) begin
                        r_slot_vic <= (r_slot_vic == KI_W'(SENDERS - 1)) ?
                                      '0 : r_slot_vic + 1'b1;
                    end else begin
                        r_slot_cnt <= r_slot_cnt + 1'b1;
                    end
                end
            end else begin
                r_k_cv <= r_ka < r_slot_cnt;
                if (r_ka < r_slot_cnt) begin
                    r_ka <= r_ka + 1'b1;
                end
            end
        end
    end

    // per-sender history window
    logic [TIME_W+SER_W-1:0] hist_mem [SENDERS * WINDOW];
    logic [TIME_W+SER_W-1:0] r_hist_rd;
    logic [HW-1:0]           r_hp;
    logic [FW-1:0]           r_hk;
    logic                    r_h_cv;
    logic                    r_h_lastd;
    logic [FW-1:0]           r_cnt;
    logic [TIME_W-1:0]       r_last_t;
    logic [SER_W-1:0]        r_last_ser;
    logic [HA_W-1:0]         h_raddr;
    logic [HA_W-1:0]         h_waddr;
    logic                    hist_done;
    logic                    recent;

    assign h_raddr   = HA_W'(r_slot) * HA_W'(WINDOW) + HA_W'(r_hp);
    assign h_waddr   = HA_W'(r_slot) * HA_W'(WINDOW) + HA_W'(r_head);
    assign hist_done = !r_h_cv && (r_hk == r_fill);
    assign recent    = ({1'b0, r_hist_rd[SER_W +: TIME_W]} + DEV_W'(ONE_SECOND_US))
                       > {1'b0, r_now};

    always_ff @(posedge i_clk) begin
        r_hist_rd <= hist_mem[h_raddr];
        if (i_cmd.wb) begin
            hist_mem[h_waddr] <= {r_now, r_ser};
        end
        if (i_cmd.hist_scan && r_h_cv && r_h_lastd) begin
            r_last_t   <= r_hist_rd[SER_W +: TIME_W];
            r_last_ser <= r_hist_rd[SER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hk      <= '0;
            r_hp      <= '0;
            r_h_cv    <= 1'b0;
            r_h_lastd <= 1'b0;
            r_cnt     <= '0;
        end else if (i_cmd.slot_scan && slot_done) begin
            r_hp   <= p0_wide[HW-1:0];
            r_hk   <= '0;
            r_h_cv <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.hist_scan) begin
            if (r_h_cv && recent) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_hk < r_fill) begin
                r_h_cv    <= 1'b1;
                r_h_lastd <= r_hk == (r_fill - 1'b1);
                r_hk      <= r_hk + 1'b1;
                r_hp      <= (r_hp == HW'(WINDOW - 1)) ? '0 : r_hp + 1'b1;
            end else begin
                r_h_cv <= 1'b0;
            end
        end
    end

    // score arithmetic
    logic [CFG_W-1:0]  e_val;
    logic [CFG_W-1:0]  r_e;
    logic              r_back;
    logic [TIME_W-1:0] r_iv;
    logic              r_serb;
    logic              r_rate;
    logic [RM_W-1:0]   r_rmul;
    logic              r_short;
    logic [DEV_W-1:0]  r_dev;
    logic [DEN_W-1:0]  r_e10;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic              r_zero;
    logic [FW+3:0]     rb_diff;
    logic              int_f;
    logic [1:0]        checks;
    logic [NUM_W-1:0]  t_int;
    logic [NUM_W-1:0]  t_ser;
    logic [NUM_W-1:0]  t_rate;
    logic [DEV_W-1:0]  e_dev;

    assign e_val   = (r_exp == '0) ? CFG_W'(1) : r_exp;
    assign rb_diff = (FW+4)'(r_cnt) - (FW+4)'(RATE_BASE);
    assign e_dev   = DEV_W'(r_e);
    assign int_f   = r_dev > DEV_W'(r_tol);
    assign checks  = 2'(int_f) + 2'(r_serb) + 2'(r_rate);
    // x * 2560 as (x << 11) + (x << 9)
    assign t_int   = int_f ? (NUM_W'(r_dev) << 11) + (NUM_W'(r_dev) << 9) : '0;
    assign t_ser   = r_serb ? (NUM_W'(r_e) << 11) + (NUM_W'(r_e) << 9) : '0;
    assign t_rate  = r_rate ? NUM_W'(r_rmul) << 8 : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_e     <= e_val;
            r_back  <= r_now < r_last_t;
            r_iv    <= (r_now < r_last_t) ? r_last_t - r_now : r_now - r_last_t;
            r_serb  <= r_ser != (r_last_ser + 1'b1);
            r_rate  <= 32'(r_cnt) > RATE_LIMIT;
            r_rmul  <= RM_W'(rb_diff) * RM_W'(e_val);
            r_short <= r_fill < FW'(2);
        end
        if (i_cmd.calc2) begin
            if (r_back) begin
                r_dev <= DEV_W'(r_iv) + e_dev;
            end else if (DEV_W'(r_iv) >= e_dev) begin
                r_dev <= DEV_W'(r_iv) - e_dev;
            end else begin
                r_dev <= e_dev - DEV_W'(r_iv);
            end
            r_e10 <= (DEN_W'(r_e) << 3) + (DEN_W'(r_e) << 1);
        end
        if (i_cmd.calc3) begin
            r_num <= t_int + t_ser + t_rate;
            case (checks)
                2'd1:    r_den <= r_e10;
                2'd2:    r_den <= r_e10 << 1;
                default: r_den <= r_e10 + (r_e10 << 1);
            endcase
            r_zero <= r_short || (checks == 2'd0);
        end
    end

    logic               div_done;
    logic [SCORE_W-1:0] div_q;

    mard_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // write-back and result
    logic [SCORE_W-1:0] score;
    logic [FW:0]        w_clamp;
    logic [FW:0]        fill_inc;
    logic [FW-1:0]      fill_new;
    logic [HW-1:0]      head_new;
    logic               over_thr;
    logic               alert;
    logic               black_new;
    logic               r_out_vld;
    logic               out_free;

    assign score     = r_zero ? '0 : div_q;
    assign w_clamp   = (r_ws == '0) ? (FW+1)'(1) :
                       ((32'(r_ws) > WINDOW) ? (FW+1)'(WINDOW) : (FW+1)'(r_ws));
    assign fill_inc  = (FW+1)'(r_fill) + 1'b1;
    assign fill_new  = (fill_inc > w_clamp) ? r_fill : fill_inc[FW-1:0];
    assign head_new  = (r_head == HW'(WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign over_thr  = score >= r_thr;
    assign alert     = r_mode ? r_replay : (r_black || over_thr);
    assign black_new = r_black || (!r_mode && over_thr);
    assign slot_wdata = {r_snd, fill_new, head_new, black_new};
    assign out_free  = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.wb) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            o_alert          <= alert;
            o_replay_seen    <= r_replay;
            o_anomaly_score  <= score;
            o_sender_blocked <= r_black;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_stat.seen_done = seen_done;
    assign o_stat.slot_done = slot_done;
    assign o_stat.hist_done = hist_done;
    assign o_stat.div_done  = div_done;
    assign o_stat.out_free  = out_free;

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen_cnt <= SC_W'(SEEN_ENTRIES)) else $error("seen fill count overrun");
    a_wb_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wb |-> out_free) else $error("result written over a pending one");

endmodule

FILE: sv/mard_ctrl.sv
module mard_ctrl import mard_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_stat i_stat,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SEEN;
            S_SEEN:   if (i_stat.seen_done) n_state = S_SLOT;
            S_SLOT:   if (i_stat.slot_done) n_state = S_HIST;
            S_HIST:   if (i_stat.hist_done) n_state = S_CALC1;
            S_CALC1:  n_state = S_CALC2;
            S_CALC2:  n_state = S_CALC3;
            S_CALC3:  n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (i_stat.div_done) n_state = S_WB;
            S_WB:     if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // no request is taken while reset is held
    assign o_in_stall      = !i_rst_n || (r_state != S_IDLE);
    assign o_cmd.start     = !o_in_stall && i_in_valid;
    assign o_cmd.seen_scan = r_state == S_SEEN;
    assign o_cmd.slot_scan = r_state == S_SLOT;
    assign o_cmd.hist_scan = r_state == S_HIST;
    assign o_cmd.calc1     = r_state == S_CALC1;
    assign o_cmd.calc2     = r_state == S_CALC2;
    assign o_cmd.calc3     = r_state == S_CALC3;
    assign o_cmd.div_start = r_state == S_DSTART;
    assign o_cmd.wb        = (r_state == S_WB) && i_stat.out_free;

    a_start_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == S_SEEN) else $error("request not taken into search");

endmodule

FILE: sv/message_anomaly_replay_detector_core.sv
// Replay and anomaly detector: one result per received message. Each request
// searches the seen-pair table one entry per cycle, then the sender table one
// entry per cycle, walks the sender's history window one entry per cycle, and
// finishes with a 16-step score divider. The linear table searches through
// their single memory read ports set how long a request takes, so it grows
// with the fill of the tables and is longest once they are full.
// The tables use fill counts, so there is no clearing pass after reset.
// A finished result waits in the output register while the next request is taken.
module message_anomaly_replay_detector_core import mard_pkg::*; #(
    parameter int SENDERS      = 64,
    parameter int WINDOW       = 16,
    parameter int SEEN_ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [SND_W-1:0]   i_sender_address,
    input  logic [SER_W-1:0]   i_serial_number,
    input  logic [TIME_W-1:0]  i_receive_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_alert,
    output logic               o_replay_seen,
    output logic [SCORE_W-1:0] o_anomaly_score,
    output logic               o_sender_blocked,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    mard_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mard_dpath #(
        .SENDERS      (SENDERS),
        .WINDOW       (WINDOW),
        .SEEN_ENTRIES (SEEN_ENTRIES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sender_address (i_sender_address),
        .i_serial_number  (i_serial_number),
        .i_receive_time   (i_receive_time),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_alert          (o_alert),
        .o_replay_seen    (o_replay_seen),
        .o_anomaly_score  (o_anomaly_score),
        .o_sender_blocked (o_sender_blocked)
    );

endmodule
